// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define NSR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// expression must never be true outside reset
`define NSR_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

// File: src/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Widths, constants and control types of the Newton square root core.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRACTION_BITS = 16;

    localparam int RADICAND_W  = 32;
    localparam int ROOT_W      = 32;
    localparam int COUNT_W     = 6;
    localparam int TOL_W       = 16;
    localparam int LIMIT_W     = 6;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int M_TDATA_W   = ((ROOT_W + COUNT_W + 7) / 8) * 8;

    localparam int PROD_W      = 2 * DATA_WIDTH;
    localparam int DIVIDEND_W  = DATA_WIDTH + FRACTION_BITS;
    localparam int DIV_STEPS   = DATA_WIDTH + FRACTION_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [DATA_WIDTH-1:0] ONE_FIXED = DATA_WIDTH'(64'd1 << FRACTION_BITS);

    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(7);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOLERANCE       = 1'b0,
        REG_ITERATION_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic div_start;
        logic div_step;
        logic update;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic limit_hit;
        logic div_last;
        logic out_busy;
    } status_t;

endpackage

// File: src/nsr_ctrl.sv
// ----------------------------------------------------------------------------
// nsr_ctrl
// Sequencer: square check, divide, update, result hand-off.
// ----------------------------------------------------------------------------
module nsr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  nsr_pkg::status_t status,
    output nsr_pkg::cmd_t    cmd
);
    import nsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.close || status.limit_hit)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/nsr_datapath.sv
// ----------------------------------------------------------------------------
// nsr_datapath
// Guess register, squarer, restoring divider, config and result registers.
// ----------------------------------------------------------------------------
module nsr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nsr_pkg::cmd_t                       cmd,
    output nsr_pkg::status_t                    status,
    input  logic [nsr_pkg::RADICAND_W-1:0]      s_tdata,
    input  logic                                cfg_we,
    input  logic [nsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nsr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nsr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [0:0]                          m_tuser
);
    import nsr_pkg::*;

    logic [TOL_W-1:0]       tol_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic                   m_valid_reg;

    logic [DATA_WIDTH-1:0]  x_reg;
    logic [DATA_WIDTH-1:0]  guess_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic [DIVIDEND_W-1:0]  dividend_reg;
    logic [DATA_WIDTH-1:0]  rem_reg;
    logic [DATA_WIDTH-1:0]  quot_reg;
    logic                   over_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;

    logic [ROOT_W-1:0]      root_reg;
    logic [COUNT_W-1:0]     updates_reg;
    logic                   hit_reg;

    logic [PROD_W-1:0]      sq;
    logic [PROD_W-1:0]      x_ext;
    logic [PROD_W-1:0]      diff;
    logic                   sq_ovf;
    logic [DATA_WIDTH:0]    rem_shift;
    logic                   rem_ge;
    logic [DATA_WIDTH-1:0]  quotient;
    logic [DATA_WIDTH-1:0]  guess_avg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= TOL_RESET;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TOLERANCE:       tol_reg   <= cfg_data[TOL_W-1:0];
                    REG_ITERATION_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.finish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // square error test on the registered square
    assign sq     = prod_reg >> FRACTION_BITS;
    assign x_ext  = PROD_W'(x_reg);
    assign diff   = (sq >= x_ext) ? (sq - x_ext) : (x_ext - sq);
    assign sq_ovf = (prod_reg >> (64 + FRACTION_BITS)) != '0;

    // one restoring divide step
    assign rem_shift = {rem_reg, dividend_reg[DIVIDEND_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, guess_reg};

    assign quotient  = (over_reg || (guess_reg == '0)) ? '1 : quot_reg;
    assign guess_avg = (guess_reg >> 1) + (quotient >> 1)
                     + DATA_WIDTH'(guess_reg[0] & quotient[0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= DATA_WIDTH'(s_tdata);
            guess_reg <= ONE_FIXED;
            count_reg <= '0;
        end
        if (cmd.square)
        begin
            prod_reg <= PROD_W'(guess_reg) * PROD_W'(guess_reg);
        end
        if (cmd.div_start)
        begin
            dividend_reg <= {x_reg, {FRACTION_BITS{1'b0}}};
            rem_reg      <= '0;
            quot_reg     <= '0;
            over_reg     <= 1'b0;
            div_cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= dividend_reg << 1;
            rem_reg      <= rem_ge ? DATA_WIDTH'(rem_shift - {1'b0, guess_reg})
                                   : rem_shift[DATA_WIDTH-1:0];
            over_reg     <= over_reg | quot_reg[DATA_WIDTH-1];
            quot_reg     <= {quot_reg[DATA_WIDTH-2:0], rem_ge};
            div_cnt_reg  <= div_cnt_reg - 1'b1;
        end
        if (cmd.update)
        begin
            guess_reg <= guess_avg;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            root_reg    <= ROOT_W'(guess_reg);
            updates_reg <= count_reg;
            hit_reg     <= ~status.close;
        end
    end

    always_comb
    begin
        status.close     = !sq_ovf && (diff < PROD_W'(tol_reg));
        status.limit_hit = count_reg >= limit_reg;
        status.div_last  = div_cnt_reg == DIV_CNT_W'(1);
        status.out_busy  = m_valid_reg && !m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({updates_reg, root_reg});
    assign m_tuser  = hit_reg;

endmodule

// File: src/newton_square_root_core.sv
// ----------------------------------------------------------------------------
// newton_square_root_core
// Unsigned fixed-point square root by Newton iteration.
// ----------------------------------------------------------------------------
// One radicand is worked on at a time. The result comes after n Newton
// updates, n being 0 up to iteration_limit (default limit of 32), at the
// default Q16.16 widths. Each update is bound by the divider, a restoring
// unit that retires one quotient bit per cycle; squaring and the error test
// come before it. A finished result sits in an output register, so the next
// radicand may be taken while it waits. Configuration must be written only
// between items; the block itself does not enforce it.
module newton_square_root_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nsr_pkg::RADICAND_W-1:0]    s_tdata,   // [31:0] radicand
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nsr_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] root, [37:32] updates_done
    output logic [0:0]                        m_tuser,   // [0] limit_reached
    input  logic                              cfg_we,
    input  logic [nsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nsr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import nsr_pkg::*;

    cmd_t    cmd;
    status_t status;

    nsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nsr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: src/nsr_checker.sv
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks of the square root core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nsr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [nsr_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [0:0]                        m_tuser
);
    import nsr_pkg::*;

    logic [ROOT_W-1:0]  root;
    logic [COUNT_W-1:0] updates;

    assign root    = m_tdata[ROOT_W-1:0];
    assign updates = m_tdata[ROOT_W+COUNT_W-1:ROOT_W];

    // stalled result beat holds
    `NSR_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one radicand in flight: no new beat right after one is taken
    `NSR_ASSERT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready |=> !s_tready)

    // a result can not appear on the beat right after acceptance
    `NSR_ASSERT(a_no_instant_result, clk, rst_n, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)

    // no update made and tolerance met means the starting guess came out
    `NSR_ASSERT_NEVER(a_start_guess, clk, rst_n, m_tvalid && updates == '0 && !m_tuser[0] && root != ROOT_W'(ONE_FIXED))

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (.*);
